@@ design/rtal_pkg.sv @@
package rtal_pkg;

    localparam int RELAYS_DEF = 4;
    localparam int IDX_W      = 4;
    localparam int SEC_W      = 32;
    localparam int LOCK_W     = 16;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [LOCK_W-1:0] MIN_LOCK_RST  = 16'd1;
    localparam logic [LOCK_W-1:0] MAX_LOCK_RST  = 16'(10 * 60);
    localparam logic [LOCK_W-1:0] GAP_FAST_RST  = 16'd5;
    localparam logic [LOCK_W-1:0] GAP_MID_RST   = 16'd10;
    localparam logic [LOCK_W-1:0] GAP_SLOW_RST  = 16'd60;
    localparam logic [SEC_W-1:0]  GAP_RESET_RST = 32'(30 * 60);
    localparam logic [LOCK_W-1:0] INC_RST       = 16'd1;

    localparam logic [LOCK_W:0] STEP_FAST = 17'd3;
    localparam logic [LOCK_W:0] STEP_MID  = 17'd2;
    localparam logic [LOCK_W:0] STEP_SLOW = 17'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LOCK  = 3'd0,
        CFG_MAX_LOCK  = 3'd1,
        CFG_GAP_FAST  = 3'd2,
        CFG_GAP_MID   = 3'd3,
        CFG_GAP_SLOW  = 3'd4,
        CFG_GAP_RESET = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_REPORT
    } t_state;

    typedef enum logic [2:0] {
        GAP_FAST,
        GAP_MID,
        GAP_SLOW,
        GAP_RESET,
        GAP_KEEP
    } t_gap;

    typedef struct packed {
        logic [LOCK_W-1:0] min_lock;
        logic [LOCK_W-1:0] max_lock;
        logic [LOCK_W-1:0] gap_fast;
        logic [LOCK_W-1:0] gap_mid;
        logic [LOCK_W-1:0] gap_slow;
        logic [SEC_W-1:0]  gap_reset;
    } t_cfg;

    typedef struct packed {
        logic             in_ready;
        logic             load;
        logic             rd_en;
        logic             rd_use_idx;
        logic [IDX_W-1:0] rd_cnt;
        logic             wr_en;
        logic             report;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic is_tick;
        logic idx_valid;
        logic out_free;
    } t_status;

endpackage

@@ design/rtal_intf.sv @@
interface rtal_req_if;
    import rtal_pkg::*;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [IDX_W-1:0] relay_index;
    logic [SEC_W-1:0] seconds;

    modport source(output valid, req_type, relay_index, seconds, input ready);
    modport sink(input valid, req_type, relay_index, seconds, output ready);
endinterface

interface rtal_res_if;
    import rtal_pkg::*;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] relay_on_mask;
    logic [SEC_W-1:0]  remaining_sec;
    logic [LOCK_W-1:0] lock_left_sec;
    logic              index_valid;

    modport source(output valid, relay_on_mask, remaining_sec, lock_left_sec, index_valid,
                   input ready);
    modport sink(input valid, relay_on_mask, remaining_sec, lock_left_sec, index_valid,
                 output ready);
endinterface

interface rtal_cfg_if;
    import rtal_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ design/relay_timer_adaptive_lockout.sv @@
// Relay on-timers with adaptive anti-chatter lockout. A tick request advances the
// seconds clock and visits every relay in turn; a set request loads one relay's
// on-time. One request is handled at a time, each giving exactly one result that
// reflects the state afterwards. A tick updates every relay, a set only the addressed
// one, or none if its index is out of range. The result register is loaded after the
// last update; the next request can be taken in the cycle after that. The per-relay
// state is read and written through one shared read/update pipeline, one relay per
// cycle. The result sits in an output register, so the next request is taken while it
// waits; a result still untaken when the next one is due holds the block until the
// output is accepted. Timing registers are written on the configuration channel
// (index 0 to 5) by the user only while idle; the block itself does not enforce this.
module relay_timer_adaptive_lockout #(
    parameter int RELAYS = rtal_pkg::RELAYS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtal_req_if.sink   i_req,
    rtal_res_if.source o_res,
    rtal_cfg_if.sink   i_cfg
);
    import rtal_pkg::*;

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_st;

    rtal_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    rtal_ctrl #(
        .RELAYS (RELAYS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    rtal_dp #(
        .RELAYS (RELAYS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .o_st    (w_st),
        .i_req   (i_req),
        .o_res   (o_res)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in progress");

    a_report_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.report |-> (!o_res.valid || o_res.ready))
        else $error("result written over one not yet taken");

    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_en |-> $past(w_cmd.rd_en))
        else $error("relay update without a preceding read");

    a_no_read_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.in_ready |-> (!w_cmd.rd_en && !w_cmd.wr_en && !w_cmd.report))
        else $error("relay access while idle");
`endif

endmodule

@@ design/rtal_cfg.sv @@
module rtal_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rtal_cfg_if.sink      i_cfg,
    output rtal_pkg::t_cfg o_cfg
);
    import rtal_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_lock  <= MIN_LOCK_RST;
            r_cfg.max_lock  <= MAX_LOCK_RST;
            r_cfg.gap_fast  <= GAP_FAST_RST;
            r_cfg.gap_mid   <= GAP_MID_RST;
            r_cfg.gap_slow  <= GAP_SLOW_RST;
            r_cfg.gap_reset <= GAP_RESET_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MIN_LOCK:  r_cfg.min_lock  <= i_cfg.data[LOCK_W-1:0];
                CFG_MAX_LOCK:  r_cfg.max_lock  <= i_cfg.data[LOCK_W-1:0];
                CFG_GAP_FAST:  r_cfg.gap_fast  <= i_cfg.data[LOCK_W-1:0];
                CFG_GAP_MID:   r_cfg.gap_mid   <= i_cfg.data[LOCK_W-1:0];
                CFG_GAP_SLOW:  r_cfg.gap_slow  <= i_cfg.data[LOCK_W-1:0];
                CFG_GAP_RESET: r_cfg.gap_reset <= i_cfg.data[SEC_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ design/rtal_ctrl.sv @@
module rtal_ctrl #(
    parameter int RELAYS = rtal_pkg::RELAYS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtal_pkg::t_status i_st,
    output rtal_pkg::t_cmd    o_cmd
);
    import rtal_pkg::*;

    localparam int CNT_W = $clog2(RELAYS + 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   w_nvis;
    logic               r_wr_en;
    logic               w_rd_en;

    // relays to visit: all of them on a tick, the addressed one on a set
    always_comb begin
        if (i_st.is_tick) begin
            w_nvis = CNT_W'(RELAYS);
        end else if (i_st.idx_valid) begin
            w_nvis = CNT_W'(1);
        end else begin
            w_nvis = '0;
        end
    end

    assign w_rd_en = (r_state == S_RUN) && (r_cnt < w_nvis);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_st.in_valid) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                if (w_rd_en) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.wr_en      = r_wr_en;
        o_cmd.rd_cnt     = IDX_W'(r_cnt);
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_st.in_valid;
            end
            S_RUN: begin
                o_cmd.rd_en      = w_rd_en;
                o_cmd.rd_use_idx = !i_st.is_tick;
            end
            S_REPORT: begin
                o_cmd.rd_use_idx = 1'b1;
                o_cmd.report     = i_st.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_wr_en <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wr_en <= w_rd_en;
        end
    end

endmodule

@@ design/rtal_dp.sv @@
module rtal_dp #(
    parameter int RELAYS = rtal_pkg::RELAYS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtal_pkg::t_cfg    i_cfg,
    input  rtal_pkg::t_cmd    i_cmd,
    output rtal_pkg::t_status o_st,
    rtal_req_if.sink          i_req,
    rtal_res_if.source        o_res
);
    import rtal_pkg::*;

    localparam int AW = (RELAYS > 1) ? $clog2(RELAYS) : 1;
    localparam logic [IDX_W:0] RELAYS_L = (IDX_W + 1)'(RELAYS);

    // latched request and seconds clock
    logic [SEC_W-1:0]  r_clock;
    logic              r_type;
    logic [IDX_W-1:0]  r_idx;
    logic [SEC_W-1:0]  r_secs;

    // per-relay state
    logic [RELAYS-1:0] r_on;
    logic [SEC_W-1:0]  r_last [RELAYS];
    logic [SEC_W-1:0]  r_rem  [RELAYS];
    logic [LOCK_W-1:0] r_lock [RELAYS];
    logic [LOCK_W-1:0] r_inc  [RELAYS];

    // read stage
    logic [AW-1:0]     r_s1_addr;
    logic              r_s1_on;
    logic [SEC_W-1:0]  r_s1_rem;
    logic [LOCK_W-1:0] r_s1_lock;
    logic [LOCK_W-1:0] r_s1_inc;
    t_gap              r_s1_gap;

    // output register
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_mask;
    logic [SEC_W-1:0]  r_out_rem;
    logic [LOCK_W-1:0] r_out_lock;
    logic              r_out_iv;

    logic              w_is_tick;
    logic              w_idx_valid;
    logic [AW-1:0]     w_addr;
    logic [SEC_W-1:0]  w_gap;
    t_gap              w_gap_cls;
    logic [MASK_W-1:0] w_mask;

    logic [LOCK_W-1:0] w_lock_dec;
    logic [SEC_W-1:0]  w_rem_n;
    logic              w_try;
    logic              w_sw_on;
    logic [LOCK_W:0]   w_v;
    logic [LOCK_W:0]   w_v_hi;
    logic [LOCK_W-1:0] w_inc_n;
    logic              w_on_n;
    logic [LOCK_W-1:0] w_lock_n;

    assign w_is_tick   = !r_type;
    assign w_idx_valid = {1'b0, r_idx} < RELAYS_L;
    assign w_addr      = i_cmd.rd_use_idx ? r_idx[AW-1:0] : i_cmd.rd_cnt[AW-1:0];

    assign i_req.ready  = i_cmd.in_ready;
    assign o_st.in_valid  = i_req.valid;
    assign o_st.is_tick   = w_is_tick;
    assign o_st.idx_valid = w_idx_valid;
    assign o_st.out_free  = !r_out_valid || o_res.ready;

    // gap classed in the read stage so the write stage only adds and clamps
    assign w_gap = r_clock - r_last[w_addr];

    always_comb begin
        if (w_gap < {16'b0, i_cfg.gap_fast}) begin
            w_gap_cls = GAP_FAST;
        end else if (w_gap < {16'b0, i_cfg.gap_mid}) begin
            w_gap_cls = GAP_MID;
        end else if (w_gap < {16'b0, i_cfg.gap_slow}) begin
            w_gap_cls = GAP_SLOW;
        end else if (w_gap > i_cfg.gap_reset) begin
            w_gap_cls = GAP_RESET;
        end else begin
            w_gap_cls = GAP_KEEP;
        end
    end

    // write stage
    always_comb begin
        w_lock_dec = r_s1_lock;
        if (w_is_tick && (r_s1_lock != '0)) begin
            w_lock_dec = r_s1_lock - LOCK_W'(1);
        end

        if (w_is_tick) begin
            w_try   = (r_s1_rem != '0);
            w_rem_n = w_try ? (r_s1_rem - SEC_W'(1)) : r_s1_rem;
        end else begin
            // a set is refused while the relay is out of time and still locked
            w_rem_n = ((r_s1_rem != '0) || (r_s1_lock == '0)) ? r_secs : r_s1_rem;
            w_try   = (w_rem_n != '0);
        end

        w_sw_on = w_try && !r_s1_on && (w_lock_dec == '0);

        case (r_s1_gap)
            GAP_FAST:  w_v = {1'b0, r_s1_inc} + STEP_FAST;
            GAP_MID:   w_v = {1'b0, r_s1_inc} + STEP_MID;
            GAP_SLOW:  w_v = {1'b0, r_s1_inc} + STEP_SLOW;
            GAP_RESET: w_v = {1'b0, i_cfg.min_lock};
            default:   w_v = {1'b0, r_s1_inc};
        endcase

        w_v_hi  = (w_v > {1'b0, i_cfg.max_lock}) ? {1'b0, i_cfg.max_lock} : w_v;
        w_inc_n = (w_v_hi < {1'b0, i_cfg.min_lock}) ? i_cfg.min_lock : w_v_hi[LOCK_W-1:0];

        w_on_n   = w_try ? (r_s1_on || w_sw_on) : 1'b0;
        w_lock_n = w_sw_on ? w_inc_n : w_lock_dec;
    end

    always_comb begin
        w_mask = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < RELAYS) begin
                w_mask[i] = r_on[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
            r_type  <= 1'b0;
            r_idx   <= '0;
            r_secs  <= '0;
            r_on    <= '0;
            for (int i = 0; i < RELAYS; i++) begin
                r_last[i] <= '0;
                r_rem[i]  <= '0;
                r_lock[i] <= '0;
                r_inc[i]  <= INC_RST;
            end
        end else begin
            if (i_cmd.load) begin
                r_type <= i_req.req_type;
                r_idx  <= i_req.relay_index;
                r_secs <= i_req.seconds;
                if (!i_req.req_type) begin
                    r_clock <= r_clock + SEC_W'(1);
                end
            end
            if (i_cmd.wr_en) begin
                r_on[r_s1_addr]   <= w_on_n;
                r_rem[r_s1_addr]  <= w_rem_n;
                r_lock[r_s1_addr] <= w_lock_n;
                if (w_sw_on) begin
                    r_inc[r_s1_addr]  <= w_inc_n;
                    r_last[r_s1_addr] <= r_clock;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_s1_addr <= w_addr;
            r_s1_on   <= r_on[w_addr];
            r_s1_rem  <= r_rem[w_addr];
            r_s1_lock <= r_lock[w_addr];
            r_s1_inc  <= r_inc[w_addr];
            r_s1_gap  <= w_gap_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.report) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_out_mask <= w_mask;
            r_out_iv   <= w_idx_valid;
            r_out_rem  <= w_idx_valid ? r_rem[w_addr] : '0;
            r_out_lock <= w_idx_valid ? r_lock[w_addr] : '0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.relay_on_mask = r_out_mask;
    assign o_res.remaining_sec = r_out_rem;
    assign o_res.lock_left_sec = r_out_lock;
    assign o_res.index_valid   = r_out_iv;

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rtal_pkg::*;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // register slots past the last one; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [MASK_W-1:0] on_mask;
        logic [SEC_W-1:0]  remaining;
        logic [LOCK_W-1:0] lock_left;
        logic              idx_ok;
    } t_relay_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rtal_req_if req_if();
    rtal_res_if res_if();
    rtal_cfg_if cfg_if();

    relay_timer_adaptive_lockout dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #4 i_clk = ~i_clk;

    // shadow of the timing registers and the per-relay state
    t_cfg              timing;
    logic [SEC_W-1:0]  seconds_now;
    logic              relay_on_q    [RELAYS_DEF];
    logic [SEC_W-1:0]  last_on_q     [RELAYS_DEF];
    logic [SEC_W-1:0]  time_left_q   [RELAYS_DEF];
    logic [LOCK_W-1:0] lockout_q     [RELAYS_DEF];
    logic [LOCK_W-1:0] lock_step_q   [RELAYS_DEF];

    t_relay_report pending_reports[$];

    int error_count;
    int cycle_count;
    int ticks_sent;
    int loads_sent;
    int loads_refused;
    int loads_out_of_range;
    int switch_ons;
    int reg_writes;
    int reports_checked;

    // sender burst state and receiver stall pattern
    int burst_left;
    int sink_mode;
    int sink_mode_left;
    int sink_stall_left;

    function automatic void reset_shadow();
        timing.min_lock  = MIN_LOCK_RST;
        timing.max_lock  = MAX_LOCK_RST;
        timing.gap_fast  = GAP_FAST_RST;
        timing.gap_mid   = GAP_MID_RST;
        timing.gap_slow  = GAP_SLOW_RST;
        timing.gap_reset = GAP_RESET_RST;
        seconds_now = '0;
        for (int r = 0; r < RELAYS_DEF; r++) begin
            relay_on_q[r]  = 1'b0;
            last_on_q[r]   = '0;
            time_left_q[r] = '0;
            lockout_q[r]   = '0;
            lock_step_q[r] = INC_RST;
        end
    endfunction

    function automatic void energise(int r);
        logic [SEC_W-1:0] gap;
        logic [SEC_W-1:0] step;
        if (!relay_on_q[r] && lockout_q[r] == '0) begin
            relay_on_q[r] = 1'b1;
            switch_ons++;
            gap  = seconds_now - last_on_q[r];
            step = {16'b0, lock_step_q[r]};
            if (gap < {16'b0, timing.gap_fast})
                step = step + SEC_W'(STEP_FAST);
            else if (gap < {16'b0, timing.gap_mid})
                step = step + SEC_W'(STEP_MID);
            else if (gap < {16'b0, timing.gap_slow})
                step = step + SEC_W'(STEP_SLOW);
            else if (gap > timing.gap_reset)
                step = {16'b0, timing.min_lock};
            if (step > {16'b0, timing.max_lock})
                step = {16'b0, timing.max_lock};
            if (step < {16'b0, timing.min_lock})
                step = {16'b0, timing.min_lock};
            lock_step_q[r] = step[LOCK_W-1:0];
            lockout_q[r]   = step[LOCK_W-1:0];
            last_on_q[r]   = seconds_now;
        end
    endfunction

    function automatic t_relay_report advance_relays(logic kind, logic [IDX_W-1:0] idx,
                                                     logic [SEC_W-1:0] secs);
        t_relay_report rep;
        logic          in_range;
        in_range = (idx < RELAYS_DEF);
        if (kind == REQ_TICK) begin
            seconds_now = seconds_now + SEC_W'(1);
            for (int r = 0; r < RELAYS_DEF; r++) begin
                if (lockout_q[r] != '0)
                    lockout_q[r] = lockout_q[r] - LOCK_W'(1);
                if (time_left_q[r] != '0) begin
                    time_left_q[r] = time_left_q[r] - SEC_W'(1);
                    energise(r);
                end else begin
                    relay_on_q[r] = 1'b0;
                end
            end
        end else if (in_range) begin
            if (time_left_q[idx] != '0 || lockout_q[idx] == '0)
                time_left_q[idx] = secs;
            else
                loads_refused++;
            if (time_left_q[idx] != '0)
                energise(idx);
            else
                relay_on_q[idx] = 1'b0;
        end
        rep.on_mask = '0;
        for (int r = 0; r < RELAYS_DEF && r < MASK_W; r++)
            rep.on_mask[r] = relay_on_q[r];
        rep.remaining = in_range ? time_left_q[idx] : '0;
        rep.lock_left = in_range ? lockout_q[idx] : '0;
        rep.idx_ok    = in_range;
        return rep;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(logic kind, logic [IDX_W-1:0] idx, logic [SEC_W-1:0] secs);
        int gap;
        req_if.valid       = 1'b1;
        req_if.req_type    = kind;
        req_if.relay_index = idx;
        req_if.seconds     = secs;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        pending_reports.push_back(advance_relays(kind, idx, secs));
        if (kind == REQ_TICK)
            ticks_sent++;
        else if (idx < RELAYS_DEF)
            loads_sent++;
        else
            loads_out_of_range++;
        @(negedge i_clk);
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(0, 24);
        end
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        req_if.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    // only while idle
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        case (idx)
            CFG_MIN_LOCK:  timing.min_lock  = data[LOCK_W-1:0];
            CFG_MAX_LOCK:  timing.max_lock  = data[LOCK_W-1:0];
            CFG_GAP_FAST:  timing.gap_fast  = data[LOCK_W-1:0];
            CFG_GAP_MID:   timing.gap_mid   = data[LOCK_W-1:0];
            CFG_GAP_SLOW:  timing.gap_slow  = data[LOCK_W-1:0];
            CFG_GAP_RESET: timing.gap_reset = data;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic load_timing(logic [CFG_DATA_W-1:0] min_l, logic [CFG_DATA_W-1:0] max_l,
                               logic [CFG_DATA_W-1:0] fast, logic [CFG_DATA_W-1:0] mid,
                               logic [CFG_DATA_W-1:0] slow, logic [CFG_DATA_W-1:0] rst_gap);
        wait_idle();
        write_register(CFG_MIN_LOCK, min_l);
        write_register(CFG_MAX_LOCK, max_l);
        write_register(CFG_GAP_FAST, fast);
        write_register(CFG_GAP_MID, mid);
        write_register(CFG_GAP_SLOW, slow);
        write_register(CFG_GAP_RESET, rst_gap);
    endtask

    // mostly ticks with loads mixed in, short on-times so relays chatter
    task automatic run_relay_traffic(int n, int load_pct, int max_secs);
        logic [IDX_W-1:0] idx;
        logic [SEC_W-1:0] secs;
        int               roll;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < load_pct) begin
                idx  = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(4, 15))
                                                   : IDX_W'($urandom_range(0, 3));
                roll = $urandom_range(0, 99);
                if (roll < 12)
                    secs = '0;
                else if (roll < 82)
                    secs = $urandom_range(1, max_secs);
                else
                    secs = $urandom;
                send_request(REQ_SET, idx, secs);
            end else begin
                send_request(REQ_TICK, IDX_W'($urandom_range(0, 15)), $urandom);
            end
        end
    endtask

    task automatic test_directed_edges();
        send_request(REQ_TICK, 0, 0);
        send_request(REQ_SET, 0, 3);
        send_request(REQ_SET, 0, 0);
        // relay off with lockout running: load must be refused
        send_request(REQ_SET, 0, 7);
        send_request(REQ_TICK, 0, 32'hFFFF_FFFF);
        send_request(REQ_TICK, 0, 0);
        send_request(REQ_SET, 1, 32'hFFFF_FFFF);
        send_request(REQ_SET, 2, 1);
        send_request(REQ_SET, 3, 2);
        send_request(REQ_SET, 4, 9);
        send_request(REQ_SET, 15, 32'hFFFF_FFFF);
        send_request(REQ_TICK, 15, 0);
        send_request(REQ_TICK, 9, 0);
        for (int i = 0; i < 6; i++)
            send_request(REQ_TICK, IDX_W'(i % 4), 0);
        send_request(REQ_SET, 0, 32'h8000_0000);
        send_request(REQ_SET, 2, 32'h5555_AAAA);
        send_request(REQ_SET, 1, 1);
        send_request(REQ_TICK, 1, 0);
        send_request(REQ_TICK, 2, 0);
    endtask

    task automatic test_default_timing();
        load_timing(CFG_DATA_W'(MIN_LOCK_RST), CFG_DATA_W'(MAX_LOCK_RST),
                    CFG_DATA_W'(GAP_FAST_RST), CFG_DATA_W'(GAP_MID_RST),
                    CFG_DATA_W'(GAP_SLOW_RST), CFG_DATA_W'(GAP_RESET_RST));
        run_relay_traffic(300, 20, 40);
    endtask

    task automatic test_fast_chatter();
        // thresholds small enough that every band and the reset path get hit
        load_timing(1, 20, 2, 4, 8, 16);
        run_relay_traffic(350, 30, 12);
    endtask

    task automatic test_flat_increment();
        load_timing(1, 1, 0, 0, 0, 0);
        run_relay_traffic(300, 35, 6);
    endtask

    task automatic test_inverted_clamp();
        load_timing(9, 3, 30, 20, 10, 5);
        write_register(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_register(CFG_SPARE_HI, 32'h0000_0001);
        run_relay_traffic(300, 30, 10);
    endtask

    task automatic test_register_ceiling();
        load_timing(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF,
                    32'h0000_FFFF, 32'hFFFF_FFFF);
        run_relay_traffic(150, 25, 8);
        // upper data bits must not leak into the 16-bit registers
        load_timing(32'hFFFF_0002, 32'hA5A5_0040, 32'h1234_0003, 32'hFFFF_0006,
                    32'h8000_000C, 32'h0000_0000);
        run_relay_traffic(150, 25, 8);
    endtask

    task automatic test_random_timing();
        for (int k = 0; k < 3; k++) begin
            load_timing($urandom_range(1, 8) | ($urandom << 16), $urandom_range(1, 80),
                        $urandom_range(0, 6), $urandom_range(0, 12), $urandom_range(0, 30),
                        $urandom_range(0, 60));
            run_relay_traffic(140, 25, 15);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_relay_report exp;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: result with nothing expected: mask %h remaining %0d lock %0d",
                         $time, res_if.relay_on_mask, res_if.remaining_sec,
                         res_if.lock_left_sec);
                error_count++;
            end else begin
                exp = pending_reports.pop_front();
                reports_checked++;
                if (res_if.relay_on_mask !== exp.on_mask) begin
                    $display("%0t: relay_on_mask expected %h actual %h", $time,
                             exp.on_mask, res_if.relay_on_mask);
                    error_count++;
                end
                if (res_if.remaining_sec !== exp.remaining) begin
                    $display("%0t: remaining_sec expected %0d actual %0d", $time,
                             exp.remaining, res_if.remaining_sec);
                    error_count++;
                end
                if (res_if.lock_left_sec !== exp.lock_left) begin
                    $display("%0t: lock_left_sec expected %0d actual %0d", $time,
                             exp.lock_left, res_if.lock_left_sec);
                    error_count++;
                end
                if (res_if.index_valid !== exp.idx_ok) begin
                    $display("%0t: index_valid expected %b actual %b", $time,
                             exp.idx_ok, res_if.index_valid);
                    error_count++;
                end
            end
        end
    end

    // receiver back-pressure: free-flowing, random, or long stalls
    always @(negedge i_clk) begin
        logic rdy;
        if (sink_mode_left == 0) begin
            sink_mode      = $urandom_range(0, 2);
            sink_mode_left = $urandom_range(50, 300);
        end else begin
            sink_mode_left--;
        end
        case (sink_mode)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(0, 99) < 70);
            default: begin
                if (sink_stall_left > 0) begin
                    sink_stall_left--;
                    rdy = 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    sink_stall_left = $urandom_range(3, 20);
                    rdy = 1'b0;
                end else begin
                    rdy = 1'b1;
                end
            end
        endcase
        res_if.ready <= rdy;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     pending_reports.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        error_count        = 0;
        cycle_count        = 0;
        ticks_sent         = 0;
        loads_sent         = 0;
        loads_refused      = 0;
        loads_out_of_range = 0;
        switch_ons         = 0;
        reg_writes         = 0;
        reports_checked    = 0;
        burst_left         = 0;
        sink_mode          = 0;
        sink_mode_left     = 0;
        sink_stall_left    = 0;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_TICK;
        req_if.relay_index = '0;
        req_if.seconds     = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_MIN_LOCK;
        cfg_if.data        = '0;
        res_if.ready       = 1'b0;
        reset_shadow();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_edges();
        test_default_timing();
        test_fast_chatter();
        test_flat_increment();
        test_inverted_clamp();
        test_register_ceiling();
        test_random_timing();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Checked %0d results: %0d ticks, %0d timer loads (%0d refused under lockout),",
                 reports_checked, ticks_sent, loads_sent, loads_refused);
        $display("%0d out-of-range loads, %0d switch-ons, %0d register writes, %0d errors",
                 loads_out_of_range, switch_ons, reg_writes, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
